>>> rtl/core/dual_slope_adc_sequencer_unit_defines.svh
// Assertion macros shared by the sequencer RTL.
`ifndef DUAL_SLOPE_ADC_SEQUENCER_UNIT_DEFINES_SVH
`define DUAL_SLOPE_ADC_SEQUENCER_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define DSADC_ASSERT_NOW(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define DSADC_ASSERT_NEXT(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/dsadc_pkg.sv
package dsadc_pkg;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_RAMP_STEPS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_STEP   = 2'd1;

    localparam logic [7:0] FIRST_RAMP_RESET = 8'd200;
    localparam logic [7:0] TICKS_RESET      = 8'h20;
    localparam logic [7:0] COUNT_MAX        = 8'd255;
    localparam logic [7:0] FULL_SCALE       = 8'd255;

    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // quotient is below 512, so nine restoring steps suffice
    localparam int DIV_STEPS = 9;
    localparam int DIV_CNT_W = 4;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_RAMP1 = 2'd1,
        PH_RAMP2 = 2'd2
    } t_phase;

    typedef struct packed {
        logic op;
        logic control_pin_level;
        logic comparator_level;
    } t_in_item;

    typedef struct packed {
        logic       drive_enable;
        logic       drive_level;
        logic       busy_res;
        logic       done_res;
        logic [7:0] result_value;
    } t_out_item;

    typedef logic [3:0] t_uaddr;

    localparam t_uaddr UA_WAIT     = 4'd0;
    localparam t_uaddr UA_OPCHK    = 4'd1;
    localparam t_uaddr UA_IDLECHK  = 4'd2;
    localparam t_uaddr UA_MATCHCHK = 4'd3;
    localparam t_uaddr UA_TICK     = 4'd4;
    localparam t_uaddr UA_PHCHK    = 4'd5;
    localparam t_uaddr UA_R1CHK    = 4'd6;
    localparam t_uaddr UA_R1END    = 4'd7;
    localparam t_uaddr UA_R2CHK    = 4'd8;
    localparam t_uaddr UA_FIN      = 4'd9;
    localparam t_uaddr UA_DIV      = 4'd10;
    localparam t_uaddr UA_DIVEND   = 4'd11;
    localparam t_uaddr UA_START    = 4'd12;
    localparam t_uaddr UA_EMIT     = 4'd15;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_LATCH,
        ACT_START,
        ACT_TICK,
        ACT_ENTER_R2,
        ACT_FINISH,
        ACT_DIV_STEP,
        ACT_DIV_DONE,
        ACT_EMIT
    } t_act;

    typedef enum logic [3:0] {
        C_ALWAYS,
        C_IN_IDLE,
        C_OP_START,
        C_PH_IDLE,
        C_MATCH,
        C_TICK_HOLD,
        C_PH_RAMP2,
        C_CNT_LT_FRS,
        C_CNT_LT_MAX,
        C_DIV_MORE,
        C_OUT_BUSY,
        C_NEVER
    } t_cond;

    typedef struct packed {
        t_act   act;
        t_cond  cond;
        t_uaddr target;
    } t_uword;

    // Control store: jump to target when cond holds, else fall through.
    function automatic t_uword uc_rom(input t_uaddr addr);
        t_uword w;
        unique case (addr)
            UA_WAIT:     w = '{ACT_LATCH,    C_IN_IDLE,    UA_WAIT};
            UA_OPCHK:    w = '{ACT_NONE,     C_OP_START,   UA_START};
            UA_IDLECHK:  w = '{ACT_NONE,     C_PH_IDLE,    UA_EMIT};
            UA_MATCHCHK: w = '{ACT_NONE,     C_MATCH,      UA_FIN};
            UA_TICK:     w = '{ACT_TICK,     C_TICK_HOLD,  UA_EMIT};
            UA_PHCHK:    w = '{ACT_NONE,     C_PH_RAMP2,   UA_R2CHK};
            UA_R1CHK:    w = '{ACT_NONE,     C_CNT_LT_FRS, UA_EMIT};
            UA_R1END:    w = '{ACT_ENTER_R2, C_ALWAYS,     UA_EMIT};
            UA_R2CHK:    w = '{ACT_NONE,     C_CNT_LT_MAX, UA_EMIT};
            UA_FIN:      w = '{ACT_FINISH,   C_NEVER,      UA_WAIT};
            UA_DIV:      w = '{ACT_DIV_STEP, C_DIV_MORE,   UA_DIV};
            UA_DIVEND:   w = '{ACT_DIV_DONE, C_ALWAYS,     UA_EMIT};
            UA_START:    w = '{ACT_START,    C_ALWAYS,     UA_EMIT};
            UA_EMIT:     w = '{ACT_EMIT,     C_OUT_BUSY,   UA_EMIT};
            default:     w = '{ACT_NONE,     C_ALWAYS,     UA_WAIT};
        endcase
        return w;
    endfunction

endpackage

>>> rtl/core/dual_slope_adc_sequencer_unit.sv
// Dual-slope integrating converter sequencer.
// Input channel (i_in_valid/o_in_ready, i_in_item): one beat is either a start
// (samples the control pin as direction) or a time tick. Every input beat gives
// exactly one output beat (o_out_valid/i_out_ready, o_out_item) showing the
// drive enable and level, busy, done and the last converted value.
// Config channel (i_cfg_valid/o_cfg_ready): index 0 first ramp steps, index 1
// ticks per step; always ready, other indexes ignored.
// Sequence: a start or an idle tick is decoded and emitted; a ramp tick also
// steps the prescaler and counter. The tick that ends a conversion, also when
// the second ramp saturates, runs the ratio through a 9-step restoring
// divider, one quotient bit per cycle. The wait step follows each emit
// before the next beat is taken. All timing is set by the microcode program
// walked one word per cycle.
// The next input beat is taken while a result still waits in the output
// register; if the receiver stalls, the sequencer holds in its emit step
// until the register drains, and input is not taken meanwhile.
// Reset (synchronous, active low): idle phase, counters and last value zero,
// registers back to 200 steps and 32 ticks, no output pending.
`include "dual_slope_adc_sequencer_unit_defines.svh"

module dual_slope_adc_sequencer_unit
    import dsadc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_item,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_data
);

    t_uaddr    r_upc, n_upc;
    t_uword    uw;
    logic      cond_hit;

    logic [7:0] r_frs, r_tps;
    t_in_item   r_item, n_item;
    t_phase     r_phase, n_phase;
    logic       r_dir, n_dir;
    logic [7:0] r_presc, n_presc;
    logic [7:0] r_cnt, n_cnt;
    logic [7:0] r_last, n_last;
    logic       r_done, n_done;

    logic [8:0]           r_den, n_den;
    logic [8:0]           r_rem, n_rem;
    logic [8:0]           r_low, n_low;
    logic [8:0]           r_quo, n_quo;
    logic [DIV_CNT_W-1:0] r_dcnt, n_dcnt;

    logic      r_out_valid, n_out_valid;
    t_out_item r_out, n_out;

    logic [7:0]  frs_eff, tps_eff, presc_inc;
    logic        ph_run;
    logic        out_busy;
    logic [8:0]  total;
    logic [15:0] num;
    logic [9:0]  trial;
    logic        trial_ge;

    assign uw       = uc_rom(r_upc);
    assign out_busy = r_out_valid && !i_out_ready;

    assign frs_eff   = (r_frs == 8'd0) ? 8'd1 : r_frs;
    assign tps_eff   = (r_tps == 8'd0) ? 8'd1 : r_tps;
    assign presc_inc = r_presc + 8'd1;
    assign ph_run    = (r_phase == PH_RAMP1) || (r_phase == PH_RAMP2);

    // ratio numerator with half-divisor rounding; fits 16 bits
    assign total = {1'b0, frs_eff} + {1'b0, r_cnt};
    assign num   = {8'd0, (r_dir ? frs_eff : r_cnt)} * {8'd0, FULL_SCALE}
                   + {8'd0, total[8:1]};

    assign trial    = {r_rem, r_low[8]};
    assign trial_ge = trial >= {1'b0, r_den};

    always_comb begin
        unique case (uw.cond)
            C_ALWAYS:     cond_hit = 1'b1;
            C_IN_IDLE:    cond_hit = !i_in_valid;
            C_OP_START:   cond_hit = (r_item.op == OP_START);
            C_PH_IDLE:    cond_hit = !ph_run;
            C_MATCH:      cond_hit = (r_phase == PH_RAMP2) && (r_presc == 8'd0)
                                     && (r_item.comparator_level == r_dir);
            C_TICK_HOLD:  cond_hit = presc_inc < tps_eff;
            C_PH_RAMP2:   cond_hit = (r_phase == PH_RAMP2);
            C_CNT_LT_FRS: cond_hit = r_cnt < frs_eff;
            C_CNT_LT_MAX: cond_hit = r_cnt < COUNT_MAX;
            C_DIV_MORE:   cond_hit = r_dcnt != DIV_CNT_W'(DIV_STEPS - 1);
            C_OUT_BUSY:   cond_hit = out_busy;
            C_NEVER:      cond_hit = 1'b0;
            default:      cond_hit = 1'b0;
        endcase
    end

    // sequencer; the emit step sits at the top so fall-through wraps to wait
    assign n_upc = cond_hit ? uw.target : r_upc + t_uaddr'(1);

    always_comb begin
        n_item      = r_item;
        n_phase     = r_phase;
        n_dir       = r_dir;
        n_presc     = r_presc;
        n_cnt       = r_cnt;
        n_last      = r_last;
        n_done      = r_done;
        n_den       = r_den;
        n_rem       = r_rem;
        n_low       = r_low;
        n_quo       = r_quo;
        n_dcnt      = r_dcnt;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;

        unique case (uw.act)
            ACT_NONE: begin
            end
            ACT_LATCH: begin
                if (i_in_valid) begin
                    n_item = i_in_item;
                    n_done = 1'b0;
                end
            end
            ACT_START: begin
                n_dir   = r_item.control_pin_level;
                n_phase = PH_RAMP1;
                n_presc = 8'd0;
                n_cnt   = 8'd0;
            end
            ACT_TICK: begin
                if (presc_inc < tps_eff) begin
                    n_presc = presc_inc;
                end else begin
                    n_presc = 8'd0;
                    n_cnt   = r_cnt + 8'd1;
                end
            end
            ACT_ENTER_R2: begin
                n_phase = PH_RAMP2;
                n_cnt   = 8'd0;
            end
            ACT_FINISH: begin
                n_den   = total;
                n_rem   = {2'b00, num[15:9]};
                n_low   = num[8:0];
                n_quo   = 9'd0;
                n_dcnt  = '0;
                n_phase = PH_IDLE;
                n_presc = 8'd0;
                n_cnt   = 8'd0;
                n_done  = 1'b1;
            end
            ACT_DIV_STEP: begin
                n_rem  = trial_ge ? 9'(trial - {1'b0, r_den}) : trial[8:0];
                n_quo  = {r_quo[7:0], trial_ge};
                n_low  = {r_low[7:0], 1'b0};
                n_dcnt = r_dcnt + DIV_CNT_W'(1);
            end
            ACT_DIV_DONE: begin
                n_last = r_quo[8] ? 8'hFF : r_quo[7:0];
            end
            ACT_EMIT: begin
                if (!out_busy) begin
                    n_out_valid        = 1'b1;
                    n_out.drive_enable = ph_run;
                    n_out.drive_level  = (r_phase == PH_RAMP1) ? r_dir :
                                         (r_phase == PH_RAMP2) ? !r_dir : 1'b0;
                    n_out.busy_res     = ph_run;
                    n_out.done_res     = r_done;
                    n_out.result_value = r_last;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc       <= UA_WAIT;
            r_phase     <= PH_IDLE;
            r_dir       <= 1'b0;
            r_presc     <= 8'd0;
            r_cnt       <= 8'd0;
            r_last      <= 8'd0;
            r_done      <= 1'b0;
            r_dcnt      <= '0;
            r_out_valid <= 1'b0;
            r_frs       <= FIRST_RAMP_RESET;
            r_tps       <= TICKS_RESET;
        end else begin
            r_upc       <= n_upc;
            r_phase     <= n_phase;
            r_dir       <= n_dir;
            r_presc     <= n_presc;
            r_cnt       <= n_cnt;
            r_last      <= n_last;
            r_done      <= n_done;
            r_dcnt      <= n_dcnt;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_FIRST_RAMP_STEPS) begin
                    r_frs <= i_cfg_data;
                end else if (i_cfg_index == CFG_TICKS_PER_STEP) begin
                    r_tps <= i_cfg_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_den  <= n_den;
        r_rem  <= n_rem;
        r_low  <= n_low;
        r_quo  <= n_quo;
        r_out  <= n_out;
    end

    assign o_in_ready  = (r_upc == UA_WAIT);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    `DSADC_ASSERT_NOW(a_done_not_busy, o_out_valid && o_out_item.done_res, !o_out_item.busy_res, "done beat reports busy")
    `DSADC_ASSERT_NOW(a_div_idle, r_upc == UA_DIV, r_phase == PH_IDLE, "dividing with conversion running")
    `DSADC_ASSERT_NOW(a_div_bound, r_upc == UA_DIV, r_dcnt < DIV_CNT_W'(DIV_STEPS), "divider overran")
    `DSADC_ASSERT_NEXT(a_accept_decode, i_in_valid && o_in_ready, r_upc == UA_OPCHK, "accepted beat not decoded")

endmodule
